/* rtl/core/latency_histogram_monitor_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the latency histogram monitor
// Implication and next-cycle checks, clocked on i_clk, held off in reset.
// ----------------------------------------------------------------------------
`ifndef LATENCY_HISTOGRAM_MONITOR_TOP_ASSERT_SVH
`define LATENCY_HISTOGRAM_MONITOR_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define LHM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lhm assertion failed");
`define LHM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lhm assertion failed");
`else
`define LHM_ASSERT_IMP(lbl, ante, cons)
`define LHM_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

/* rtl/core/lhm_pkg.sv */
// ----------------------------------------------------------------------------
// Latency histogram monitor package
// Widths, bucket bounds, function codes, sequencer states and shared structs.
// ----------------------------------------------------------------------------
package lhm_pkg;

    localparam int PHASES   = 17;
    localparam int BUCKETS  = 18;
    localparam int DEPTH    = PHASES * BUCKETS;

    localparam int FUNC_W   = 2;
    localparam int PHASE_FW = 5;
    localparam int DUR_W    = 40;
    localparam int CNT_W    = 32;
    localparam int SUM_W    = 48;
    localparam int US_W     = 18;

    localparam int PH_W     = (PHASES > 1) ? $clog2(PHASES) : 1;
    localparam int BKT_W    = $clog2(BUCKETS);
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int N_W      = CNT_W + $clog2(BUCKETS);
    localparam int CMP_W    = N_W + 7;

    localparam int APB_AW   = 1;
    localparam int APB_DW   = 32;

    localparam logic [APB_AW-1:0] ADDR_TRACE_EN = '0;

    localparam logic [FUNC_W-1:0] FN_RECORD = 2'd0;
    localparam logic [FUNC_W-1:0] FN_READ   = 2'd1;
    localparam logic [FUNC_W-1:0] FN_CLEAR  = 2'd2;

    localparam logic [US_W-1:0] OVERFLOW_US = 18'd250001;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_FIND,
        S_BRD,
        S_RD,
        S_ACC,
        S_TGT,
        S_C50,
        S_C95,
        S_OUT
    } t_state;

    typedef enum logic {
        CM_BUCKET,
        CM_PCT
    } t_cmp_mode;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CNT_W-1:0]  wdata;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

    typedef struct packed {
        t_cmp_mode         mode;
        logic [BKT_W-1:0]  idx;
        logic [DUR_W-1:0]  ns;
        logic [N_W-1:0]    acc;
        logic [CMP_W-1:0]  target;
    } t_cmp_req;

    typedef struct packed {
        logic clearing;
        logic out_load;
    } t_ctrl_status;

    function automatic logic [US_W-1:0] bound_us(input logic [BKT_W-1:0] idx);
        logic [US_W-1:0] v;
        case (idx)
            BKT_W'(0):  v = US_W'(25);
            BKT_W'(1):  v = US_W'(50);
            BKT_W'(2):  v = US_W'(100);
            BKT_W'(3):  v = US_W'(200);
            BKT_W'(4):  v = US_W'(500);
            BKT_W'(5):  v = US_W'(1000);
            BKT_W'(6):  v = US_W'(2000);
            BKT_W'(7):  v = US_W'(4000);
            BKT_W'(8):  v = US_W'(8000);
            BKT_W'(9):  v = US_W'(12000);
            BKT_W'(10): v = US_W'(16667);
            BKT_W'(11): v = US_W'(25000);
            BKT_W'(12): v = US_W'(33333);
            BKT_W'(13): v = US_W'(50000);
            BKT_W'(14): v = US_W'(75000);
            BKT_W'(15): v = US_W'(100000);
            BKT_W'(16): v = US_W'(250000);
            default:    v = OVERFLOW_US;
        endcase
        return v;
    endfunction

    // bucket upper bound scaled to ns: ceil(ns/1000) <= b  iff  ns <= 1000*b
    function automatic logic [CMP_W-1:0] bound_ns(input logic [BKT_W-1:0] idx);
        logic [CMP_W-1:0] v;
        case (idx)
            BKT_W'(0):  v = CMP_W'(64'd25000);
            BKT_W'(1):  v = CMP_W'(64'd50000);
            BKT_W'(2):  v = CMP_W'(64'd100000);
            BKT_W'(3):  v = CMP_W'(64'd200000);
            BKT_W'(4):  v = CMP_W'(64'd500000);
            BKT_W'(5):  v = CMP_W'(64'd1000000);
            BKT_W'(6):  v = CMP_W'(64'd2000000);
            BKT_W'(7):  v = CMP_W'(64'd4000000);
            BKT_W'(8):  v = CMP_W'(64'd8000000);
            BKT_W'(9):  v = CMP_W'(64'd12000000);
            BKT_W'(10): v = CMP_W'(64'd16667000);
            BKT_W'(11): v = CMP_W'(64'd25000000);
            BKT_W'(12): v = CMP_W'(64'd33333000);
            BKT_W'(13): v = CMP_W'(64'd50000000);
            BKT_W'(14): v = CMP_W'(64'd75000000);
            BKT_W'(15): v = CMP_W'(64'd100000000);
            BKT_W'(16): v = CMP_W'(64'd250000000);
            default:    v = '1;
        endcase
        return v;
    endfunction

endpackage

/* rtl/core/lhm_if.sv */
// ----------------------------------------------------------------------------
// Latency histogram monitor stream interfaces
// Command channel and statistics result channel, valid/ready transfer.
// ----------------------------------------------------------------------------
interface lhm_in_if;
    import lhm_pkg::*;

    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [PHASE_FW-1:0] phase;
    logic [DUR_W-1:0]    duration_ns;

    modport source (output valid, output func, output phase, output duration_ns,
                    input ready);
    modport sink   (input valid, input func, input phase, input duration_ns,
                    output ready);
endinterface

interface lhm_out_if;
    import lhm_pkg::*;

    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] sample_total;
    logic [SUM_W-1:0] sum_ns;
    logic [DUR_W-1:0] peak_ns;
    logic [US_W-1:0]  p50_us;
    logic [US_W-1:0]  p95_us;

    modport source (output valid, output sample_total, output sum_ns, output peak_ns,
                    output p50_us, output p95_us, input ready);
    modport sink   (input valid, input sample_total, input sum_ns, input peak_ns,
                    input p50_us, input p95_us, output ready);
endinterface

/* rtl/core/lhm_apb_regs.sv */
// ----------------------------------------------------------------------------
// Latency histogram monitor register port
// APB-style write/read of the trace enable register.
// ----------------------------------------------------------------------------
module lhm_apb_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lhm_pkg::APB_AW-1:0]  paddr,
    input  logic [lhm_pkg::APB_DW-1:0]  pwdata,
    output logic [lhm_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    output logic                        o_trace_en
);
    import lhm_pkg::*;

    logic r_trace_en;
    logic n_trace_en;

    always_comb begin
        n_trace_en = r_trace_en;
        if (psel && penable && pwrite && (paddr == ADDR_TRACE_EN)) begin
            n_trace_en = pwdata[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trace_en <= 1'b0;
        end else begin
            r_trace_en <= n_trace_en;
        end
    end

    assign pready     = 1'b1;
    assign prdata     = (paddr == ADDR_TRACE_EN) ? {{(APB_DW-1){1'b0}}, r_trace_en} : '0;
    assign o_trace_en = r_trace_en;

endmodule

/* rtl/core/lhm_hist_ram.sv */
// ----------------------------------------------------------------------------
// Latency histogram monitor bucket memory
// One write and one registered read per cycle, phase-major bucket layout.
// ----------------------------------------------------------------------------
module lhm_hist_ram (
    input  logic                       i_clk,
    input  lhm_pkg::t_ram_req          i_req,
    output logic [lhm_pkg::CNT_W-1:0]  o_rdata
);
    import lhm_pkg::*;

    logic [CNT_W-1:0] r_mem [DEPTH];
    logic [CNT_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/lhm_cmp_unit.sv */
// ----------------------------------------------------------------------------
// Latency histogram monitor shared compare unit
// Bucket bound test for a duration, or scaled cumulative count test for a
// percentile target, one compare per cycle.
// ----------------------------------------------------------------------------
module lhm_cmp_unit (
    input  lhm_pkg::t_cmp_req i_req,
    output logic              o_hit
);
    import lhm_pkg::*;

    logic [CMP_W-1:0] w_acc;
    logic [CMP_W-1:0] w_lhs;
    logic [CMP_W-1:0] w_rhs;

    assign w_acc = CMP_W'(i_req.acc);

    always_comb begin
        case (i_req.mode)
            CM_BUCKET: begin
                w_lhs = bound_ns(i_req.idx);
                w_rhs = CMP_W'(i_req.ns);
            end
            CM_PCT: begin
                w_lhs = (w_acc << 6) + (w_acc << 5) + (w_acc << 2);
                w_rhs = i_req.target;
            end
            default: begin
                w_lhs = '0;
                w_rhs = '1;
            end
        endcase
    end

    assign o_hit = (w_lhs >= w_rhs);

endmodule

/* rtl/core/lhm_ctrl.sv */
// ----------------------------------------------------------------------------
// Latency histogram monitor sequencer
// Command decode, bucket search, histogram update, percentile walk,
// phase totals and the result register.
// ----------------------------------------------------------------------------
module lhm_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_trace_en,
    lhm_in_if.sink                     i_in,
    lhm_out_if.source                  o_out,
    output lhm_pkg::t_ram_req          o_ram_req,
    input  logic [lhm_pkg::CNT_W-1:0]  i_ram_rdata,
    output lhm_pkg::t_cmp_req          o_cmp_req,
    input  logic                       i_cmp_hit,
    output lhm_pkg::t_ctrl_status      o_status
);
    import lhm_pkg::*;

    t_state            r_state, n_state;
    logic [PH_W-1:0]   r_phase, n_phase;
    logic [ADDR_W-1:0] r_base, n_base;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [DUR_W-1:0]  r_ns, n_ns;
    logic [BKT_W-1:0]  r_idx, n_idx;
    logic              r_pass, n_pass;
    logic [N_W-1:0]    r_acc, n_acc;
    logic [N_W-1:0]    r_n, n_n;
    logic [CMP_W-1:0]  r_t50, n_t50;
    logic [CMP_W-1:0]  r_t95, n_t95;
    logic [US_W-1:0]   r_p50, n_p50;
    logic [US_W-1:0]   r_p95, n_p95;
    logic              r_f50, n_f50;
    logic              r_f95, n_f95;

    logic [CNT_W-1:0]  r_cnt  [PHASES];
    logic [SUM_W-1:0]  r_sum  [PHASES];
    logic [DUR_W-1:0]  r_peak [PHASES];

    logic              r_ovalid;
    logic [CNT_W-1:0]  r_o_total;
    logic [SUM_W-1:0]  r_o_sum;
    logic [DUR_W-1:0]  r_o_peak;
    logic [US_W-1:0]   r_o_p50;
    logic [US_W-1:0]   r_o_p95;

    logic              w_take;
    logic              w_ph_ok;
    logic              w_last;
    logic              w_find_done;
    logic [BKT_W-1:0]  w_bkt;
    logic [N_W-1:0]    w_acc_sum;
    logic [CMP_W-1:0]  w_n_ext;
    logic              w_load;
    logic              w_clr_all;
    logic              w_rec;
    logic [SUM_W:0]    w_sum_add;

    assign w_take      = i_in.valid && i_in.ready;
    assign w_ph_ok     = ({1'b0, i_in.phase} < (PHASE_FW+1)'(PHASES));
    assign w_last      = (r_idx == BKT_W'(BUCKETS-1));
    assign w_find_done = i_cmp_hit || (r_idx == BKT_W'(BUCKETS-2));
    assign w_bkt       = i_cmp_hit ? r_idx : BKT_W'(BUCKETS-1);
    assign w_acc_sum   = r_acc + N_W'(i_ram_rdata);
    assign w_n_ext     = CMP_W'(r_n);
    assign w_load      = (r_state == S_OUT) && (!r_ovalid || o_out.ready);
    assign w_clr_all   = (r_state == S_IDLE) && w_take && (i_in.func == FN_CLEAR);
    assign w_rec       = (r_state == S_BRD);
    assign w_sum_add   = {1'b0, r_sum[r_phase]} + (SUM_W+1)'(r_ns);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_addr == ADDR_W'(DEPTH-1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_take) begin
                    case (i_in.func)
                        FN_RECORD: begin
                            if (w_ph_ok && i_trace_en) begin
                                n_state = S_FIND;
                            end
                        end
                        FN_READ: begin
                            if (w_ph_ok) begin
                                n_state = S_RD;
                            end
                        end
                        FN_CLEAR: begin
                            n_state = S_CLEAR;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_FIND: begin
                if (w_find_done) begin
                    n_state = S_BRD;
                end
            end
            S_BRD:   n_state = S_IDLE;
            S_RD:    n_state = S_ACC;
            S_ACC: begin
                if (r_pass) begin
                    n_state = S_C50;
                end else begin
                    n_state = w_last ? S_TGT : S_RD;
                end
            end
            S_TGT:   n_state = S_RD;
            S_C50:   n_state = S_C95;
            S_C95:   n_state = w_last ? S_OUT : S_RD;
            S_OUT: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmp_req.mode   = CM_PCT;
        o_cmp_req.idx    = r_idx;
        o_cmp_req.ns     = r_ns;
        o_cmp_req.acc    = r_acc;
        o_cmp_req.target = r_t50;
        case (r_state)
            S_FIND:  o_cmp_req.mode   = CM_BUCKET;
            S_C95:   o_cmp_req.target = r_t95;
            default: o_cmp_req.target = r_t50;
        endcase
    end

    always_comb begin
        n_phase = r_phase;
        n_base  = r_base;
        n_addr  = r_addr;
        n_ns    = r_ns;
        n_idx   = r_idx;
        n_pass  = r_pass;
        n_acc   = r_acc;
        n_n     = r_n;
        n_t50   = r_t50;
        n_t95   = r_t95;
        n_p50   = r_p50;
        n_p95   = r_p95;
        n_f50   = r_f50;
        n_f95   = r_f95;

        o_ram_req.we    = 1'b0;
        o_ram_req.waddr = r_base + ADDR_W'(r_idx);
        o_ram_req.wdata = '0;
        o_ram_req.raddr = r_base + ADDR_W'(r_idx);

        case (r_state)
            S_CLEAR: begin
                o_ram_req.we    = 1'b1;
                o_ram_req.waddr = r_addr;
                n_addr          = r_addr + ADDR_W'(1);
            end
            S_IDLE: begin
                if (w_take) begin
                    n_phase = i_in.phase[PH_W-1:0];
                    n_base  = ADDR_W'(i_in.phase[PH_W-1:0]) * ADDR_W'(BUCKETS);
                    n_ns    = i_in.duration_ns;
                    n_idx   = '0;
                    n_acc   = '0;
                    n_pass  = 1'b0;
                    n_addr  = '0;
                end
            end
            S_FIND: begin
                if (w_find_done) begin
                    n_idx           = w_bkt;
                    o_ram_req.raddr = r_base + ADDR_W'(w_bkt);
                end else begin
                    n_idx = r_idx + BKT_W'(1);
                end
            end
            S_BRD: begin
                o_ram_req.we    = 1'b1;
                o_ram_req.wdata = (i_ram_rdata == '1) ? i_ram_rdata
                                                      : i_ram_rdata + CNT_W'(1);
            end
            S_ACC: begin
                n_acc = w_acc_sum;
                if (r_pass) begin
                    o_ram_req.we = 1'b1;
                end else if (w_last) begin
                    n_n = w_acc_sum;
                end else begin
                    n_idx = r_idx + BKT_W'(1);
                end
            end
            S_TGT: begin
                n_t50  = (w_n_ext << 5) + (w_n_ext << 4) + (w_n_ext << 1);
                n_t95  = (w_n_ext << 6) + (w_n_ext << 5) - w_n_ext;
                n_acc  = '0;
                n_idx  = '0;
                n_pass = 1'b1;
                n_f50  = 1'b0;
                n_f95  = 1'b0;
                n_p50  = OVERFLOW_US;
                n_p95  = OVERFLOW_US;
            end
            S_C50: begin
                if (i_cmp_hit && !r_f50) begin
                    n_p50 = bound_us(r_idx);
                    n_f50 = 1'b1;
                end
            end
            S_C95: begin
                if (i_cmp_hit && !r_f95) begin
                    n_p95 = bound_us(r_idx);
                    n_f95 = 1'b1;
                end
                if (!w_last) begin
                    n_idx = r_idx + BKT_W'(1);
                end
            end
            default: begin
                n_idx = r_idx;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_addr  <= '0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_phase <= n_phase;
        r_base  <= n_base;
        r_ns    <= n_ns;
        r_idx   <= n_idx;
        r_pass  <= n_pass;
        r_acc   <= n_acc;
        r_n     <= n_n;
        r_t50   <= n_t50;
        r_t95   <= n_t95;
        r_p50   <= n_p50;
        r_p95   <= n_p95;
        r_f50   <= n_f50;
        r_f95   <= n_f95;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_clr_all) begin
            for (int i = 0; i < PHASES; i++) begin
                r_cnt[i]  <= '0;
                r_sum[i]  <= '0;
                r_peak[i] <= '0;
            end
        end else if (w_rec) begin
            if (r_cnt[r_phase] != '1) begin
                r_cnt[r_phase] <= r_cnt[r_phase] + CNT_W'(1);
            end
            r_sum[r_phase] <= w_sum_add[SUM_W] ? '1 : w_sum_add[SUM_W-1:0];
            if (r_ns > r_peak[r_phase]) begin
                r_peak[r_phase] <= r_ns;
            end
        end else if (w_load) begin
            r_cnt[r_phase]  <= '0;
            r_sum[r_phase]  <= '0;
            r_peak[r_phase] <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_load) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_o_total <= r_cnt[r_phase];
            r_o_sum   <= r_sum[r_phase];
            r_o_peak  <= r_peak[r_phase];
            r_o_p50   <= (r_n == '0) ? '0 : r_p50;
            r_o_p95   <= (r_n == '0) ? '0 : r_p95;
        end
    end

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_ovalid;
    assign o_out.sample_total = r_o_total;
    assign o_out.sum_ns       = r_o_sum;
    assign o_out.peak_ns      = r_o_peak;
    assign o_out.p50_us       = r_o_p50;
    assign o_out.p95_us       = r_o_p95;

    assign o_status.clearing  = (r_state == S_CLEAR);
    assign o_status.out_load  = w_load;

endmodule

/* rtl/core/latency_histogram_monitor_top.sv */
// ----------------------------------------------------------------------------
// Latency histogram monitor
// Per-phase sample count, duration sum, peak and 18-bucket histogram with
// read-and-clear reporting of p50 and p95 bucket bounds.
// ----------------------------------------------------------------------------
//  channel  dir  transfer       payload
//  i_in     in   valid & ready  func, phase, duration_ns
//  o_out    out  valid & ready  sample_total, sum_ns, peak_ns, p50_us, p95_us
//  apb      in   psel&penable   trace_enable at offset 0
//
//  Record: a bucket search of one bound per cycle, then a bucket update.
//  Read-and-clear: two passes over the 18 buckets of one memory port.
//  Clear-all and reset: memory clearing pass over all 306 words, input not ready meanwhile.
//  A waiting result does not block the input; a second read waits for it.
// ----------------------------------------------------------------------------
`include "latency_histogram_monitor_top_assert.svh"

module latency_histogram_monitor_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lhm_pkg::APB_AW-1:0]  paddr,
    input  logic [lhm_pkg::APB_DW-1:0]  pwdata,
    output logic [lhm_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    lhm_in_if.sink                      i_in,
    lhm_out_if.source                   o_out
);
    import lhm_pkg::*;

    logic             w_trace_en;
    t_ram_req         w_ram_req;
    logic [CNT_W-1:0] w_ram_rdata;
    t_cmp_req         w_cmp_req;
    logic             w_cmp_hit;
    t_ctrl_status     w_status;
    logic             w_out_empty;

    lhm_apb_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_trace_en (w_trace_en)
    );

    lhm_hist_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (w_ram_req),
        .o_rdata (w_ram_rdata)
    );

    lhm_cmp_unit u_cmp (
        .i_req (w_cmp_req),
        .o_hit (w_cmp_hit)
    );

    lhm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_trace_en  (w_trace_en),
        .i_in        (i_in),
        .o_out       (o_out),
        .o_ram_req   (w_ram_req),
        .i_ram_rdata (w_ram_rdata),
        .o_cmp_req   (w_cmp_req),
        .i_cmp_hit   (w_cmp_hit),
        .o_status    (w_status)
    );

    assign w_out_empty = (o_out.sample_total == '0);

    `LHM_ASSERT_IMP(a_no_take_in_clear, w_status.clearing, !(i_in.valid && i_in.ready))
    `LHM_ASSERT_NXT(a_load_shows_result, w_status.out_load, o_out.valid)
    `LHM_ASSERT_IMP(a_pct_order, o_out.valid, o_out.p50_us <= o_out.p95_us)
    `LHM_ASSERT_IMP(a_empty_phase, o_out.valid && w_out_empty, ~|o_out.sum_ns && ~|o_out.p95_us)

endmodule
